FILE: rtl/vtm_pkg.sv
// Shared types, constants and ring-pointer helpers for the virtual terminal mux.
package vtm_pkg;

  localparam int TERMINALS = 4;
  localparam int IN_DEPTH  = 16;
  localparam int OUT_DEPTH = 64;

  localparam int TIDX_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int IP_W   = $clog2(2 * IN_DEPTH);
  localparam int IS_W   = $clog2(IN_DEPTH);
  localparam int HP_W   = $clog2(2 * OUT_DEPTH);
  localparam int HS_W   = $clog2(OUT_DEPTH);
  localparam int HC_W   = $clog2(OUT_DEPTH + 1);
  localparam int IA_W   = $clog2(TERMINALS * IN_DEPTH);
  localparam int HA_W   = $clog2(TERMINALS * OUT_DEPTH);

  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_SELECT = 2'd3;

  localparam logic [4:0] KC_F1   = 5'd1;
  localparam logic [4:0] KC_F12  = 5'd12;
  localparam logic [4:0] KC_UP   = 5'd13;
  localparam logic [4:0] KC_LEFT = 5'd16;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_A   = 8'h41;

  // byte source for an input ring write
  localparam logic [1:0] PUT_KEY    = 2'd0;
  localparam logic [1:0] PUT_ESC    = 2'd1;
  localparam logic [1:0] PUT_LBR    = 2'd2;
  localparam logic [1:0] PUT_LETTER = 2'd3;

  // result source
  localparam logic [2:0] ES_ECHO       = 3'd0;
  localparam logic [2:0] ES_RD_EMPTY   = 3'd1;
  localparam logic [2:0] ES_RD_DATA    = 3'd2;
  localparam logic [2:0] ES_RDRW_EMPTY = 3'd3;
  localparam logic [2:0] ES_RDRW_DATA  = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] terminal;
    logic [7:0] key_char;
    logic [4:0] key_code;
    logic       key_alt;
    logic [7:0] write_byte;
  } vtm_in_t;

  typedef struct packed {
    logic       kind;
    logic       screen_clear;
    logic       has_char;
    logic [7:0] out_char;
    logic       last;
  } vtm_out_t;

  typedef struct packed {
    logic       load_req;
    logic       in_put;
    logic [1:0] put_sel;
    logic       hist_write;
    logic       in_read;
    logic       redraw_start;
    logic       hist_read;
    logic       emit;
    logic [2:0] emit_src;
  } vtm_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       key_char_nz;
    logic       alt_fn;
    logic       arrow;
    logic       wbyte_nz;
    logic       term_ok;
    logic       tgt_ok;
    logic       term_is_act;
    logic       in_empty;
    logic       hist_empty;
    logic       redraw_done;
    logic       out_free;
  } vtm_stat_t;

  // pointers run modulo twice the depth so full and empty differ
  function automatic logic [IP_W-1:0] in_next(input logic [IP_W-1:0] p);
    return (p == IP_W'(2 * IN_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IS_W-1:0] in_slot(input logic [IP_W-1:0] p);
    logic [IP_W-1:0] d;
    d = (p >= IP_W'(IN_DEPTH)) ? p - IP_W'(IN_DEPTH) : p;
    return d[IS_W-1:0];
  endfunction

  function automatic logic in_full(input logic [IP_W-1:0] h, input logic [IP_W-1:0] t);
    logic [IP_W:0] u;
    u = (h >= t) ? {1'b0, h} - {1'b0, t}
                 : {1'b0, h} + (IP_W+1)'(2 * IN_DEPTH) - {1'b0, t};
    return u >= (IP_W+1)'(IN_DEPTH);
  endfunction

  function automatic logic [HP_W-1:0] hist_next(input logic [HP_W-1:0] p);
    return (p == HP_W'(2 * OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [HS_W-1:0] hist_slot(input logic [HP_W-1:0] p);
    logic [HP_W-1:0] d;
    d = (p >= HP_W'(OUT_DEPTH)) ? p - HP_W'(OUT_DEPTH) : p;
    return d[HS_W-1:0];
  endfunction

  function automatic logic [HP_W:0] hist_used_w(input logic [HP_W-1:0] h,
                                               input logic [HP_W-1:0] t);
    return (h >= t) ? {1'b0, h} - {1'b0, t}
                    : {1'b0, h} + (HP_W+1)'(2 * OUT_DEPTH) - {1'b0, t};
  endfunction

  function automatic logic hist_full(input logic [HP_W-1:0] h, input logic [HP_W-1:0] t);
    return hist_used_w(h, t) >= (HP_W+1)'(OUT_DEPTH);
  endfunction

  function automatic logic [HC_W-1:0] hist_used(input logic [HP_W-1:0] h,
                                               input logic [HP_W-1:0] t);
    logic [HP_W:0] u;
    u = hist_used_w(h, t);
    if (u > (HP_W+1)'(OUT_DEPTH)) u = (HP_W+1)'(OUT_DEPTH);
    return u[HC_W-1:0];
  endfunction

endpackage

FILE: rtl/vtm_dp.sv
// Datapath: request register, ring pointers, input and history memories, result register.
module vtm_dp import vtm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  vtm_in_t   in_data,
  input  vtm_cmd_t  cmd,
  output vtm_stat_t st,
  output logic      out_valid,
  input  logic      out_stall,
  output vtm_out_t  out_data
);

  vtm_in_t            req_r;
  logic [TIDX_W-1:0]  act_r;
  logic [IP_W-1:0]    in_head_r   [TERMINALS];
  logic [IP_W-1:0]    in_tail_r   [TERMINALS];
  logic [HP_W-1:0]    hist_head_r [TERMINALS];
  logic [HP_W-1:0]    hist_tail_r [TERMINALS];
  logic [TIDX_W-1:0]  rd_t_r;
  logic [HP_W-1:0]    rd_p_r;
  logic [HC_W-1:0]    cnt_r;
  logic               first_r;
  logic [7:0]         in_rdata_r;
  logic [7:0]         hist_rdata_r;
  logic               out_valid_r;
  vtm_out_t           out_r;
  vtm_out_t           out_nxt;

  logic [7:0] in_mem   [TERMINALS * IN_DEPTH];
  logic [7:0] hist_mem [TERMINALS * OUT_DEPTH];

  logic [4:0]        tgt;
  logic [4:0]        kc_off;
  logic [TIDX_W-1:0] hidx;
  logic [TIDX_W-1:0] iidx;
  logic [IP_W-1:0]   ih;
  logic [IP_W-1:0]   it;
  logic [HP_W-1:0]   hh;
  logic [HP_W-1:0]   ht;
  logic [7:0]        put_byte;
  logic              in_we;
  logic              out_free;
  logic [IA_W-1:0]   iaddr_w;
  logic [IA_W-1:0]   iaddr_r;
  logic [HA_W-1:0]   haddr_w;
  logic [HA_W-1:0]   haddr_r;

  // key events select by function key, everything else by the terminal field
  assign tgt    = (req_r.command == CMD_KEY) ? req_r.key_code - KC_F1 : {3'b000, req_r.terminal};
  assign kc_off = req_r.key_code - KC_UP;
  assign hidx   = tgt[TIDX_W-1:0];
  assign iidx   = (req_r.command == CMD_KEY) ? act_r : tgt[TIDX_W-1:0];
  assign ih     = in_head_r[iidx];
  assign it     = in_tail_r[iidx];
  assign hh     = hist_head_r[hidx];
  assign ht     = hist_tail_r[hidx];

  always_comb begin
    case (cmd.put_sel)
      PUT_KEY:    put_byte = req_r.key_char;
      PUT_ESC:    put_byte = CH_ESC;
      PUT_LBR:    put_byte = CH_LBR;
      PUT_LETTER: put_byte = CH_A + {6'b000000, kc_off[1:0]};
      default:    put_byte = req_r.key_char;
    endcase
  end

  assign in_we    = cmd.in_put && !in_full(ih, it);
  assign out_free = !out_valid_r || !out_stall;

  assign iaddr_w = IA_W'(iidx) * IA_W'(IN_DEPTH) + IA_W'(in_slot(ih));
  assign iaddr_r = IA_W'(iidx) * IA_W'(IN_DEPTH) + IA_W'(in_slot(it));
  assign haddr_w = HA_W'(hidx) * HA_W'(OUT_DEPTH) + HA_W'(hist_slot(hh));
  assign haddr_r = HA_W'(rd_t_r) * HA_W'(OUT_DEPTH) + HA_W'(hist_slot(rd_p_r));

  always_comb begin
    st.cmd         = req_r.command;
    st.key_char_nz = req_r.key_char != 8'd0;
    st.alt_fn      = req_r.key_alt && req_r.key_code >= KC_F1 && req_r.key_code <= KC_F12;
    st.arrow       = req_r.key_code >= KC_UP && req_r.key_code <= KC_LEFT;
    st.wbyte_nz    = req_r.write_byte != 8'd0;
    st.term_ok     = {3'b000, req_r.terminal} < 5'(TERMINALS);
    st.tgt_ok      = tgt < 5'(TERMINALS);
    st.term_is_act = tgt[TIDX_W-1:0] == act_r;
    st.in_empty    = ih == it;
    st.hist_empty  = hh == ht;
    st.redraw_done = cnt_r == '0;
    st.out_free    = out_free;
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.emit_src)
      ES_ECHO: begin
        out_nxt.has_char = 1'b1;
        out_nxt.out_char = req_r.write_byte;
        out_nxt.last     = 1'b1;
      end
      ES_RD_EMPTY: begin
        out_nxt.kind = 1'b1;
        out_nxt.last = 1'b1;
      end
      ES_RD_DATA: begin
        out_nxt.kind     = 1'b1;
        out_nxt.has_char = 1'b1;
        out_nxt.out_char = in_rdata_r;
        out_nxt.last     = 1'b1;
      end
      ES_RDRW_EMPTY: begin
        out_nxt.screen_clear = 1'b1;
        out_nxt.last         = 1'b1;
      end
      ES_RDRW_DATA: begin
        out_nxt.screen_clear = first_r;
        out_nxt.has_char     = 1'b1;
        out_nxt.out_char     = hist_rdata_r;
        out_nxt.last         = cnt_r == '0;
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      rd_t_r      <= '0;
      rd_p_r      <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        in_head_r[i]   <= '0;
        in_tail_r[i]   <= '0;
        hist_head_r[i] <= '0;
        hist_tail_r[i] <= '0;
      end
    end else begin
      if (in_we) in_head_r[iidx] <= in_next(ih);
      if (cmd.in_read) in_tail_r[iidx] <= in_next(it);
      if (cmd.hist_write) begin
        // full ring drops its oldest byte
        if (hist_full(hh, ht)) hist_tail_r[hidx] <= hist_next(ht);
        hist_head_r[hidx] <= hist_next(hh);
      end
      if (cmd.redraw_start) begin
        act_r   <= hidx;
        rd_t_r  <= hidx;
        rd_p_r  <= ht;
        cnt_r   <= hist_used(hh, ht);
        first_r <= 1'b1;
      end
      if (cmd.hist_read) begin
        rd_p_r <= hist_next(rd_p_r);
        cnt_r  <= cnt_r - 1'b1;
      end
      if (cmd.emit && cmd.emit_src == ES_RDRW_DATA) first_r <= 1'b0;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_data;
    if (cmd.emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_we) in_mem[iaddr_w] <= put_byte;
    if (cmd.in_read) in_rdata_r <= in_mem[iaddr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_write) hist_mem[haddr_w] <= req_r.write_byte;
    if (cmd.hist_read) hist_rdata_r <= hist_mem[haddr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result register overwritten while held");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HC_W'(OUT_DEPTH))
    else $error("redraw count beyond history depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_read |-> (ih != it))
    else $error("read from empty input ring");

endmodule

FILE: rtl/vtm_ctrl.sv
// Controller: sequences one request at a time through the datapath.
module vtm_ctrl import vtm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  vtm_stat_t st,
  output vtm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_ARROW   = 3'd2;
  localparam logic [2:0] S_RDWAIT  = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_RDRW_RD = 3'd5;
  localparam logic [2:0] S_RDRW_EM = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic [2:0] esrc_r, esrc_nxt;
  logic       do_sel;

  assign in_stall = state_r != S_IDLE;
  assign do_sel   = (st.cmd == CMD_SELECT) ||
                    (st.cmd == CMD_KEY && !st.key_char_nz && st.alt_fn);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    esrc_nxt  = esrc_r;
    cmd       = '0;
    cmd.emit_src = esrc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (do_sel) begin
          if (st.tgt_ok) begin
            cmd.redraw_start = 1'b1;
            if (st.hist_empty) begin
              esrc_nxt  = ES_RDRW_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RDRW_RD;
            end
          end
        end else begin
          case (st.cmd)
            CMD_KEY: begin
              if (st.key_char_nz) begin
                cmd.in_put  = 1'b1;
                cmd.put_sel = PUT_KEY;
              end else if (st.arrow) begin
                step_nxt  = 2'd0;
                state_nxt = S_ARROW;
              end
            end
            CMD_WRITE: begin
              if (st.term_ok && st.wbyte_nz) begin
                cmd.hist_write = 1'b1;
                if (st.term_is_act) begin
                  esrc_nxt  = ES_ECHO;
                  state_nxt = S_EMIT;
                end
              end
            end
            CMD_READ: begin
              if (st.term_ok && !st.in_empty) begin
                cmd.in_read = 1'b1;
                state_nxt   = S_RDWAIT;
              end else begin
                esrc_nxt  = ES_RD_EMPTY;
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ARROW: begin
        // ESC, '[' and the letter, each dropped alone when the ring is full
        cmd.in_put = 1'b1;
        case (step_r)
          2'd0:    cmd.put_sel = PUT_ESC;
          2'd1:    cmd.put_sel = PUT_LBR;
          default: cmd.put_sel = PUT_LETTER;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd2) state_nxt = S_IDLE;
      end
      S_RDWAIT: begin
        esrc_nxt  = ES_RD_DATA;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RDRW_RD: begin
        cmd.hist_read = 1'b1;
        esrc_nxt      = ES_RDRW_DATA;
        state_nxt     = S_RDRW_EM;
      end
      S_RDRW_EM: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.redraw_done ? S_IDLE : S_RDRW_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
      esrc_r  <= ES_ECHO;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      esrc_r  <= esrc_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_EXEC)
    else $error("accepted request not executed");

  a_arrow_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ARROW |-> step_r <= 2'd2)
    else $error("arrow sequence overran");

  a_rdwait_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDWAIT |=> (state_r == S_EMIT && esrc_r == ES_RD_DATA))
    else $error("read data not forwarded");

endmodule

FILE: rtl/virtual_terminal_mux_unit.sv
// Top level of the virtual terminal mux: controller plus datapath.
// Requests are taken one at a time. A key press, an ignored request or a
// non-echoed write passes through the decode state only; an arrow key passes
// through the decode state, then one input-ring write per queued byte; an
// echoed write or a read response goes through the emit state and may wait
// for the result register. A redraw reads and then emits each history byte
// in turn, paced by the single history memory port and its registered read;
// a redraw of an empty history may also wait for the result register.
// The result register lets a new request be accepted while the previous
// result is still held by out_stall.
module virtual_terminal_mux_unit import vtm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vtm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vtm_out_t out_data
);

  vtm_cmd_t  cmd;
  vtm_stat_t st;

  vtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  vtm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
